@@ hw/rtl/stq_pkg.sv @@
// stq_pkg: shared types and codes for the stable priority queue
// used by stq_ctrl, stq_datapath and stable_priority_queue
`timescale 1ns / 1ps

package stq_pkg;

    // entry fields
    typedef logic signed [15:0] prio_t;
    typedef logic [31:0]        pay_t;

    // operation codes carried by the mode bit
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

    // width of the reported entry count
    localparam int unsigned COUNT_OUT_W = 5;

endpackage

@@ hw/rtl/stq_ctrl.sv @@
// stq_ctrl: two-state sequencer that takes a word, runs one queue update
// and raises the result strobe; depends on stq_pkg
`timescale 1ns / 1ps

module stq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output logic            done,
    output stq_pkg::dp_cmd_t cmd
);
    import stq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // state and strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == S_EXEC);
    assign done = done_reg;

endmodule

@@ hw/rtl/stq_datapath.sv @@
// stq_datapath: row of sorted cells with local compare and shift, count
// register and result registers; depends on stq_pkg
`timescale 1ns / 1ps

module stq_datapath #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  stq_pkg::dp_cmd_t  cmd,
    input  logic              mode,
    input  stq_pkg::prio_t    priority_req,
    input  stq_pkg::pay_t     payload,
    output stq_pkg::pay_t     removed_payload,
    output stq_pkg::pay_t     head_payload,
    output stq_pkg::prio_t    head_priority,
    output logic [4:0]        entry_count,
    output logic [1:0]        status,
    output logic [$clog2(CAPACITY+1)-1:0] held_count
);
    import stq_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    // captured request word
    logic  mode_reg;
    prio_t prio_in_reg;
    pay_t  pay_in_reg;

    // cells
    prio_t prio_reg [CAPACITY];
    pay_t  pay_reg  [CAPACITY];
    prio_t prio_next [CAPACITY];
    pay_t  pay_next  [CAPACITY];
    logic [CAPACITY-1:0] le;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // result registers
    pay_t      removed_reg;
    pay_t      head_pay_reg;
    prio_t     head_prio_reg;
    logic [CNT_W-1:0] count_out_reg;
    status_t   status_reg;

    logic      is_full;
    logic      is_empty;
    logic      do_insert;
    logic      do_remove;
    status_t   status_next;
    pay_t      removed_next;

    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign do_insert = (op_t'(mode_reg) == OP_INSERT) && !is_full;
    assign do_remove = (op_t'(mode_reg) == OP_REMOVE) && !is_empty;

    // capture the request word on accept
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg    <= mode;
            prio_in_reg <= priority_req;
            pay_in_reg  <= payload;
        end
    end

    // per cell: compare against the new priority, pick keep, new or neighbor
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic prev_le;

        assign le[i] = (CNT_W'(i) < count_reg) && (prio_reg[i] <= prio_in_reg);

        if (i == 0)
        begin : g_first
            assign prev_le = 1'b1;
        end
        else
        begin : g_rest
            assign prev_le = le[i-1];
        end

        always_comb
        begin
            prio_next[i] = prio_reg[i];
            pay_next[i]  = pay_reg[i];
            if (do_insert && !le[i])
            begin
                if (prev_le)
                begin
                    prio_next[i] = prio_in_reg;
                    pay_next[i]  = pay_in_reg;
                end
                else
                begin
                    prio_next[i] = prio_reg[(i == 0) ? 0 : i - 1];
                    pay_next[i]  = pay_reg[(i == 0) ? 0 : i - 1];
                end
            end
            else if (do_remove && (i < CAPACITY - 1))
            begin
                prio_next[i] = prio_reg[(i < CAPACITY - 1) ? i + 1 : i];
                pay_next[i]  = pay_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end

        // cell storage, no reset: only cells below the count are read
        always_ff @(posedge clk)
        begin
            if (cmd.execute)
            begin
                prio_reg[i] <= prio_next[i];
                pay_reg[i]  <= pay_next[i];
            end
        end
    end

    // count and status of this step
    always_comb
    begin
        count_next   = count_reg;
        status_next  = ST_OK;
        removed_next = '0;
        if (op_t'(mode_reg) == OP_INSERT)
        begin
            if (is_full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (is_empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                count_next   = count_reg - CNT_W'(1);
                removed_next = pay_reg[0];
            end
        end
    end

    // count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    // result registers, loaded as the step completes
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            removed_reg   <= removed_next;
            count_out_reg <= count_next;
            status_reg    <= status_next;
            if (count_next != '0)
            begin
                head_pay_reg  <= pay_next[0];
                head_prio_reg <= prio_next[0];
            end
            else
            begin
                head_pay_reg  <= '0;
                head_prio_reg <= '0;
            end
        end
    end

    // low bits of the count, zero extended when the count is narrow
    logic [CNT_W+COUNT_OUT_W-1:0] count_wide;
    assign count_wide = {{COUNT_OUT_W{1'b0}}, count_out_reg};

    assign removed_payload = removed_reg;
    assign head_payload    = head_pay_reg;
    assign head_priority   = head_prio_reg;
    assign entry_count     = count_wide[COUNT_OUT_W-1:0];
    assign status          = status_reg;
    assign held_count      = count_reg;

endmodule

@@ hw/rtl/stable_priority_queue.sv @@
// stable_priority_queue: top level joining the sequencer and the cell row
// depends on stq_pkg, stq_ctrl and stq_datapath
`timescale 1ns / 1ps

// Bounded priority queue, lowest priority first, equal priorities in
// arrival order.
// Request channel: a word (mode, priority_req, payload) is taken at a
// clock edge where start is high and busy is low. mode 0 inserts the
// entry, mode 1 removes the head.
// Result channel: done is high for exactly one cycle per request and the
// result ports hold removed_payload, head_payload, head_priority,
// entry_count and status for that cycle. The receiver cannot stall.
// The accepting edge registers the word and enters the update state;
// the cell row, result registers and done are loaded as it ends. busy
// is high for the one cycle in which the cell row updates; no word is
// taken then, but the cycle in which done is high may accept the next.
// Every cell compares its priority with the new one in parallel and
// shifts locally, so the update is done within the update state at any CAPACITY.
// Insert on a full queue drops the word (status 2); remove on an empty
// queue leaves it unchanged (status 1).
// Reset clears the count and the controller; the queue starts empty.

module stable_priority_queue #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic signed [15:0] priority_req,
    input  logic [31:0] payload,
    output logic        done,
    output logic [31:0] removed_payload,
    output logic [31:0] head_payload,
    output logic signed [15:0] head_priority,
    output logic [4:0]  entry_count,
    output logic [1:0]  status
);
    import stq_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    dp_cmd_t          cmd;
    logic [CNT_W-1:0] held_count;

    // sequencer
    stq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // cell row and result registers
    stq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .mode            (mode),
        .priority_req    (priority_req),
        .payload         (payload),
        .removed_payload (removed_payload),
        .head_payload    (head_payload),
        .head_priority   (head_priority),
        .entry_count     (entry_count),
        .status          (status),
        .held_count      (held_count)
    );

    // an accepted word always leads to busy, then to the strobe
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not start an update");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("update did not end in a result strobe");

    // the count never exceeds the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // a remove on an empty queue reports an empty queue and nothing removed
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_EMPTY) |->
            (removed_payload == '0) && (head_payload == '0) &&
            (head_priority == '0) && (held_count == '0))
        else $error("remove on empty queue reported data");

endmodule
